// ===== rtl/texture_texel_fetch_decode_core_macros.svh =====
// Assertion macros shared by the texel fetch RTL.
`ifndef TEXTURE_TEXEL_FETCH_DECODE_CORE_MACROS_SVH
`define TEXTURE_TEXEL_FETCH_DECODE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TTFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define TTFD_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define TTFD_ASSERT(lbl, clk, rst, prop)
`define TTFD_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/ttfd_pkg.sv =====
// Shared types, constants and texel expansion functions of the texel fetch core.
`default_nettype none
package ttfd_pkg;

   localparam int MEM_BYTES   = 65536;
   localparam int ADDR_W      = $clog2(MEM_BYTES);
   localparam int BANKS       = 4;
   localparam int LANE_W      = $clog2(BANKS);
   localparam int ROW_W       = ADDR_W - LANE_W;
   localparam int ROWS        = MEM_BYTES / BANKS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [3:0] FMT_RGB332   = 4'd0;
   localparam logic [3:0] FMT_A8       = 4'd1;
   localparam logic [3:0] FMT_I8       = 4'd2;
   localparam logic [3:0] FMT_AI44     = 4'd3;
   localparam logic [3:0] FMT_RGB565   = 4'd4;
   localparam logic [3:0] FMT_ARGB1555 = 4'd5;
   localparam logic [3:0] FMT_ARGB8888 = 4'd6;
   localparam logic [3:0] FMT_ARGB4444 = 4'd7;

   localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;
   localparam logic [23:0] WHITE_RGB    = 24'hFF_FFFF;

   typedef struct packed {
      logic              command;
      logic [3:0]        fmt;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wbyte;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

   // log2 of bytes per texel
   function automatic logic [1:0] texel_shift(input logic [3:0] fmt);
      logic [1:0] sh;
      unique case (fmt)
         FMT_RGB332, FMT_A8, FMT_I8, FMT_AI44:  sh = 2'd0;
         FMT_RGB565, FMT_ARGB1555, FMT_ARGB4444: sh = 2'd1;
         default:                                sh = 2'd2;
      endcase
      return sh;
   endfunction

   function automatic logic [7:0] widen2(input logic [1:0] v);
      return {v, v, v, v};
   endfunction

   function automatic logic [7:0] widen3(input logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction

   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [31:0] expand_texel(input logic [3:0] fmt, input logic [31:0] raw);
      logic [7:0]  b0;
      logic [15:0] h;
      logic [7:0]  lum;
      logic [31:0] argb;
      b0  = raw[7:0];
      h   = raw[15:0];
      lum = widen4(b0[3:0]);
      unique case (fmt)
         FMT_RGB332:   argb = {8'hFF, widen3(b0[7:5]), widen3(b0[4:2]), widen2(b0[1:0])};
         FMT_A8:       argb = {b0, WHITE_RGB};
         FMT_I8:       argb = {8'hFF, b0, b0, b0};
         FMT_AI44:     argb = {widen4(b0[7:4]), lum, lum, lum};
         FMT_RGB565:   argb = {8'hFF, widen5(h[15:11]), widen6(h[10:5]), widen5(h[4:0])};
         FMT_ARGB1555: argb = {{8{h[15]}}, widen5(h[14:10]), widen5(h[9:5]), widen5(h[4:0])};
         FMT_ARGB8888: argb = raw;
         FMT_ARGB4444: argb = {widen4(h[15:12]), widen4(h[11:8]), widen4(h[7:4]),
                               widen4(h[3:0])};
         default:      argb = OPAQUE_BLACK;
      endcase
      return argb;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ttfd_queue.sv =====
// Transaction queue between the classify front end and the memory back end.
`default_nettype none
`include "texture_texel_fetch_decode_core_macros.svh"
module ttfd_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire ttfd_pkg::queue_entry_type  push_entry,
   input  wire logic                       pop,
   output ttfd_pkg::queue_entry_type       pop_entry,
   output ttfd_pkg::queue_status_type      status
);

   ttfd_pkg::queue_entry_type         entries_ff [ttfd_pkg::QUEUE_DEPTH];
   logic [ttfd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ttfd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ttfd_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry       = entries_ff[rd_ptr_ff];
   assign status.full     = (count_ff == ttfd_pkg::QCNT_W'(ttfd_pkg::QUEUE_DEPTH));
   assign status.nonempty = (count_ff != '0);

   `TTFD_ASSERT_NEVER(a_no_overflow, clock, reset, push && status.full && !pop)
   `TTFD_ASSERT_NEVER(a_no_underflow, clock, reset, pop && !status.nonempty)
   `TTFD_ASSERT(a_count_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
   `TTFD_ASSERT(a_ptr_gap, clock, reset,
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule
`default_nettype wire

// ===== rtl/ttfd_front.sv =====
// Front end: accept transactions, classify the format and form the byte address.
`default_nettype none
module ttfd_front (
   input  wire logic                       start,
   input  wire logic                       req_command,
   input  wire logic [3:0]                 req_texel_format,
   input  wire logic [3:0]                 req_level_of_detail,
   input  wire logic [15:0]                req_s_coord,
   input  wire logic [15:0]                req_t_coord,
   input  wire logic [23:0]                req_texture_base,
   input  wire logic [23:0]                req_write_address,
   input  wire logic [7:0]                 req_write_byte,
   input  wire ttfd_pkg::queue_status_type q_status,
   output logic                            busy,
   output logic                            push,
   output ttfd_pkg::queue_entry_type       push_entry
);

   logic [31:0] side_mask;
   logic [31:0] texel_idx;
   logic [31:0] byte_off;
   logic [31:0] lookup_addr;

   always_comb begin
      side_mask   = (32'd1 << req_level_of_detail) - 32'd1;
      texel_idx   = ({16'd0, req_s_coord} & side_mask)
                  + (({16'd0, req_t_coord} & side_mask) << req_level_of_detail);
      byte_off    = texel_idx << ttfd_pkg::texel_shift(req_texel_format);
      lookup_addr = {8'd0, req_texture_base} + byte_off;
   end

   always_comb begin
      busy             = q_status.full;
      push             = start && !busy;
      push_entry.command = req_command;
      push_entry.fmt     = req_texel_format;
      push_entry.wbyte   = req_write_byte;
      if (req_command == ttfd_pkg::CMD_LOOKUP) begin
         push_entry.addr = lookup_addr[ttfd_pkg::ADDR_W-1:0];
      end else begin
         push_entry.addr = req_write_address[ttfd_pkg::ADDR_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ttfd_back.sv =====
// Back end: four-bank byte memory, texel read and ARGB expansion.
`default_nettype none
`include "texture_texel_fetch_decode_core_macros.svh"
module ttfd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ttfd_pkg::queue_status_type q_status,
   input  wire ttfd_pkg::queue_entry_type  pop_entry,
   output logic                            pop,
   output logic                            rsp_valid,
   output logic [31:0]                     rsp_texel_argb
);

   logic                            is_lookup;
   logic                            is_write;
   logic [ttfd_pkg::ROW_W-1:0]      bank_row [ttfd_pkg::BANKS];
   logic [ttfd_pkg::BANKS-1:0]      bank_we;
   logic [7:0]                      rdata_ff [ttfd_pkg::BANKS];
   logic                            rd_valid_ff, rd_valid_in;
   logic [3:0]                      rd_fmt_ff;
   logic [ttfd_pkg::LANE_W-1:0]     rd_lane_ff;
   logic [31:0]                     raw_texel;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [31:0]                     rsp_texel_ff;

   assign pop       = q_status.nonempty;
   assign is_lookup = pop && (pop_entry.command == ttfd_pkg::CMD_LOOKUP);
   assign is_write  = pop && (pop_entry.command == ttfd_pkg::CMD_WRITE);

   always_comb begin
      logic [ttfd_pkg::LANE_W-1:0] k;
      logic [ttfd_pkg::ADDR_W-1:0] baddr;
      for (int j = 0; j < ttfd_pkg::BANKS; j++) begin
         k = ttfd_pkg::LANE_W'(j) - pop_entry.addr[ttfd_pkg::LANE_W-1:0];
         baddr = pop_entry.addr + ttfd_pkg::ADDR_W'(k);
         bank_row[j] = baddr[ttfd_pkg::ADDR_W-1:ttfd_pkg::LANE_W];
         bank_we[j]  = is_write
                     && (pop_entry.addr[ttfd_pkg::LANE_W-1:0] == ttfd_pkg::LANE_W'(j));
      end
   end

   for (genvar g = 0; g < ttfd_pkg::BANKS; g++) begin : g_bank
      logic [7:0] bank_mem [ttfd_pkg::ROWS];
      always_ff @(posedge clock) begin
         if (bank_we[g]) begin
            bank_mem[bank_row[g]] <= pop_entry.wbyte;
         end
         if (is_lookup) begin
            rdata_ff[g] <= bank_mem[bank_row[g]];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < ttfd_pkg::BANKS; k++) begin
         raw_texel[8*k +: 8] = rdata_ff[rd_lane_ff + ttfd_pkg::LANE_W'(k)];
      end
   end

   assign rd_valid_in  = is_lookup;
   assign rsp_valid_in = rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (is_lookup) begin
         rd_fmt_ff  <= pop_entry.fmt;
         rd_lane_ff <= pop_entry.addr[ttfd_pkg::LANE_W-1:0];
      end
      if (rd_valid_ff) begin
         rsp_texel_ff <= ttfd_pkg::expand_texel(rd_fmt_ff, raw_texel);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_texel_argb = rsp_texel_ff;

   `TTFD_ASSERT(a_read_gives_rsp, clock, reset, rd_valid_ff |=> rsp_valid_ff)
   `TTFD_ASSERT(a_no_read_no_rsp, clock, reset, !rd_valid_ff |=> !rsp_valid_ff)
   `TTFD_ASSERT(a_write_no_read, clock, reset, is_write |=> !rd_valid_ff)
   `TTFD_ASSERT_NEVER(a_write_one_bank, clock, reset, is_write && !$onehot(bank_we))

endmodule
`default_nettype wire

// ===== rtl/texture_texel_fetch_decode_core.sv =====
// Top level of the texel fetch and format expansion core.
// The core takes one transaction per clock while busy is low: a write stores one byte
// of the 64 KiB texture memory, a lookup reads a 1, 2 or 4 byte texel and expands it to
// 32-bit ARGB. The memory is split into four byte banks, so all bytes of a texel are
// read in the same cycle and the sustained rate is one transaction per clock. A lookup
// goes through the queue, bank read and result registers and shows its result on
// rsp_texel_argb with rsp_valid high for one cycle; writes give no result. Transactions
// retire in order, so a lookup sees every write accepted before it. The receiver cannot
// stall, so busy only rises if the four-entry queue between the front and back ends fills,
// which the back end, draining one entry per clock, never lets happen in steady operation.
`default_nettype none
module texture_texel_fetch_decode_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [3:0]  req_texel_format,
   input  wire logic [3:0]  req_level_of_detail,
   input  wire logic [15:0] req_s_coord,
   input  wire logic [15:0] req_t_coord,
   input  wire logic [23:0] req_texture_base,
   input  wire logic [23:0] req_write_address,
   input  wire logic [7:0]  req_write_byte,
   output logic             rsp_valid,
   output logic [31:0]      rsp_texel_argb
);

   ttfd_pkg::queue_status_type q_status;
   ttfd_pkg::queue_entry_type  push_entry;
   ttfd_pkg::queue_entry_type  pop_entry;
   logic                       push;
   logic                       pop;

   ttfd_front u_front (
      .start               (start),
      .req_command         (req_command),
      .req_texel_format    (req_texel_format),
      .req_level_of_detail (req_level_of_detail),
      .req_s_coord         (req_s_coord),
      .req_t_coord         (req_t_coord),
      .req_texture_base    (req_texture_base),
      .req_write_address   (req_write_address),
      .req_write_byte      (req_write_byte),
      .q_status            (q_status),
      .busy                (busy),
      .push                (push),
      .push_entry          (push_entry)
   );

   ttfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   ttfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_texel_argb (rsp_texel_argb)
   );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the texel fetch and format expansion core.
`default_nettype none
module testbench;

   localparam int          MEM_MASK     = ttfd_pkg::MEM_BYTES - 1;
   localparam logic [3:0]  FMT_LAST     = ttfd_pkg::FMT_ARGB4444;
   localparam logic [15:0] HOT_BASE     = 16'h4000;
   localparam int          ITEM_TARGET  = 520;
   localparam int          IDLE_LIMIT   = 1000;
   localparam int          MAX_REPORTED = 10;

   typedef struct {
      logic        command;
      logic [3:0]  fmt;
      logic [3:0]  lod;
      logic [15:0] s;
      logic [15:0] t;
      logic [23:0] base;
      logic [23:0] waddr;
      logic [7:0]  wbyte;
      bit          drain;
   } texel_txn_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = ttfd_pkg::CMD_WRITE;
   logic [3:0]  req_texel_format = '0;
   logic [3:0]  req_level_of_detail = '0;
   logic [15:0] req_s_coord = '0;
   logic [15:0] req_t_coord = '0;
   logic [23:0] req_texture_base = '0;
   logic [23:0] req_write_address = '0;
   logic [7:0]  req_write_byte = '0;
   logic        rsp_valid;
   logic [31:0] rsp_texel_argb;

   texel_txn_type pending_txns[$];
   logic [31:0]   expected_argb[$];
   logic [7:0]    texel_mem [0:ttfd_pkg::MEM_BYTES-1];
   bit            written [0:ttfd_pkg::MEM_BYTES-1];
   bit            hold_next = 1'b0;
   int            error_count = 0;
   int            idle_cycles = 0;
   int            burst_left = 20;
   int            gap_left = 0;
   texel_txn_type accepted_txn;
   logic [31:0]   want_argb;

   texture_texel_fetch_decode_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_texel_format(req_texel_format),
      .req_level_of_detail(req_level_of_detail),
      .req_s_coord(req_s_coord),
      .req_t_coord(req_t_coord),
      .req_texture_base(req_texture_base),
      .req_write_address(req_write_address),
      .req_write_byte(req_write_byte),
      .rsp_valid(rsp_valid),
      .rsp_texel_argb(rsp_texel_argb)
   );

   initial forever #5 clock = ~clock;

   function automatic int texel_bytes(logic [3:0] fmt);
      if (fmt <= ttfd_pkg::FMT_AI44) return 1;
      if (fmt == ttfd_pkg::FMT_RGB565 || fmt == ttfd_pkg::FMT_ARGB1555 ||
          fmt == ttfd_pkg::FMT_ARGB4444) return 2;
      return 4;
   endfunction

   function automatic logic [31:0] texel_address(logic [3:0] fmt, logic [3:0] lod,
                                                 logic [15:0] s, logic [15:0] t,
                                                 logic [23:0] base);
      logic [31:0] side;
      logic [31:0] idx;
      side = 32'd1 << lod;
      idx  = (32'(s) & (side - 1)) + (32'(t) & (side - 1)) * side;
      return (32'(base) + idx * texel_bytes(fmt)) & MEM_MASK;
   endfunction

   function automatic logic [7:0] stretch(logic [7:0] v, int n);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7 - i] = v[n - 1 - (i % n)];
      return r;
   endfunction

   function automatic logic [31:0] predict_argb(texel_txn_type x);
      logic [31:0] a;
      logic [7:0]  b0;
      logic [15:0] h;
      logic [7:0]  lum;
      a   = texel_address(x.fmt, x.lod, x.s, x.t, x.base);
      b0  = texel_mem[a[15:0]];
      h   = {texel_mem[16'(a + 1)], b0};
      lum = stretch(b0[3:0], 4);
      case (x.fmt)
         ttfd_pkg::FMT_RGB332:   return {8'hFF, stretch(b0[7:5], 3), stretch(b0[4:2], 3),
                                         stretch(b0[1:0], 2)};
         ttfd_pkg::FMT_A8:       return {b0, 24'hFF_FFFF};
         ttfd_pkg::FMT_I8:       return {8'hFF, b0, b0, b0};
         ttfd_pkg::FMT_AI44:     return {stretch(b0[7:4], 4), lum, lum, lum};
         ttfd_pkg::FMT_RGB565:   return {8'hFF, stretch(h[15:11], 5), stretch(h[10:5], 6),
                                         stretch(h[4:0], 5)};
         ttfd_pkg::FMT_ARGB1555: return {stretch(h[15], 1), stretch(h[14:10], 5),
                                         stretch(h[9:5], 5), stretch(h[4:0], 5)};
         ttfd_pkg::FMT_ARGB8888: return {texel_mem[16'(a + 3)], texel_mem[16'(a + 2)], h};
         ttfd_pkg::FMT_ARGB4444: return {stretch(h[15:12], 4), stretch(h[11:8], 4),
                                         stretch(h[7:4], 4), stretch(h[3:0], 4)};
         default:                return ttfd_pkg::OPAQUE_BLACK;
      endcase
   endfunction

   task automatic push_txn(texel_txn_type x);
      x.drain   = hold_next;
      hold_next = 1'b0;
      pending_txns.push_back(x);
   endtask

   task automatic add_write(logic [23:0] waddr, logic [7:0] wbyte);
      texel_txn_type x;
      x.command = ttfd_pkg::CMD_WRITE;
      x.fmt     = 4'($urandom);
      x.lod     = 4'($urandom);
      x.s       = 16'($urandom);
      x.t       = 16'($urandom);
      x.base    = 24'($urandom);
      x.waddr   = waddr;
      x.wbyte   = wbyte;
      written[waddr[15:0]] = 1'b1;
      push_txn(x);
   endtask

   task automatic add_lookup(logic [3:0] fmt, logic [3:0] lod, logic [15:0] s,
                             logic [15:0] t, logic [23:0] base);
      texel_txn_type x;
      logic [31:0]   a;
      logic [15:0]   ba;
      int            n;
      n = (fmt > FMT_LAST) ? 0 : texel_bytes(fmt);
      a = texel_address(fmt, lod, s, t, base);
      for (int k = 0; k < n; k++) begin
         ba = 16'(a + k);
         if (!written[ba]) add_write({8'($urandom), ba}, 8'($urandom));
      end
      x.command = ttfd_pkg::CMD_LOOKUP;
      x.fmt     = fmt;
      x.lod     = lod;
      x.s       = s;
      x.t       = t;
      x.base    = base;
      x.waddr   = 24'($urandom);
      x.wbyte   = 8'($urandom);
      push_txn(x);
   endtask

   task automatic drive_txn(texel_txn_type x);
      req_command         <= x.command;
      req_texel_format    <= x.fmt;
      req_level_of_detail <= x.lod;
      req_s_coord         <= x.s;
      req_t_coord         <= x.t;
      req_texture_base    <= x.base;
      req_write_address   <= x.waddr;
      req_write_byte      <= x.wbyte;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accepted_txn = pending_txns.pop_front();
            if (accepted_txn.command == ttfd_pkg::CMD_WRITE)
               texel_mem[accepted_txn.waddr[15:0]] = accepted_txn.wbyte;
            else
               expected_argb.push_back(predict_argb(accepted_txn));
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (pending_txns.size() > 0 &&
                         !(pending_txns[0].drain && expected_argb.size() != 0)) begin
               drive_txn(pending_txns[0]);
               start <= 1'b1;
               burst_left = burst_left - 1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_argb.size() == 0) begin
            if (error_count < MAX_REPORTED)
               $display("%0t: unexpected result %h", $realtime, rsp_texel_argb);
            error_count++;
         end else begin
            want_argb = expected_argb.pop_front();
            if (rsp_texel_argb !== want_argb) begin
               if (error_count < MAX_REPORTED)
                  $display("%0t: texel_argb mismatch: expected %h, actual %h",
                           $realtime, want_argb, rsp_texel_argb);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      int next_drain;
      for (int k = 0; k < 4; k++) add_write(24'(k), 8'hFF);
      for (int f = 0; f <= FMT_LAST; f++) add_lookup(4'(f), 4'd0, 16'd0, 16'd0, 24'd0);
      for (int k = 0; k < 4; k++) add_write(24'hFF_0100 + 24'(k), 8'h00);
      add_lookup(ttfd_pkg::FMT_RGB332, 4'd0, 16'd0, 16'd0, 24'h00_0100);
      add_lookup(ttfd_pkg::FMT_ARGB1555, 4'd0, 16'd0, 16'd0, 24'h00_0100);
      add_lookup(ttfd_pkg::FMT_ARGB8888, 4'd0, 16'd0, 16'd0, 24'hAB_0100);
      add_lookup(4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
      add_lookup(ttfd_pkg::FMT_ARGB8888, 4'd0, 16'd0, 16'd0, 24'hFF_FFFF);
      add_lookup(ttfd_pkg::FMT_ARGB4444, 4'hF, 16'hFFFF, 16'hFFFF, 24'd0);
      add_lookup(ttfd_pkg::FMT_RGB565, 4'd11, 16'hFFFF, 16'hFFFF, 24'($urandom));
      hold_next  = 1'b1;
      next_drain = pending_txns.size() + 150;
      while (pending_txns.size() < ITEM_TARGET) begin
         if (pending_txns.size() >= next_drain) begin
            hold_next  = 1'b1;
            next_drain = next_drain + 150;
         end
         r = $urandom_range(0, 99);
         if (r < 25) begin
            add_write({8'($urandom), HOT_BASE + 16'($urandom_range(0, 1023))},
                      8'($urandom));
         end else if (r < 85) begin
            add_lookup(($urandom_range(0, 9) == 0) ?
                          4'($urandom_range(int'(FMT_LAST) + 1, 15)) :
                          4'($urandom_range(0, int'(FMT_LAST))),
                       4'($urandom_range(0, 4)), 16'($urandom), 16'($urandom),
                       {8'($urandom), HOT_BASE + 16'($urandom_range(0, 255))});
         end else begin
            add_lookup(4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                       24'($urandom));
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_txns.size() != 0 || expected_argb.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_argb.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== texture_texel_fetch_decode_core.f =====
+incdir+rtl
rtl/ttfd_pkg.sv
rtl/ttfd_queue.sv
rtl/ttfd_front.sv
rtl/ttfd_back.sv
rtl/texture_texel_fetch_decode_core.sv
sim/testbench.sv
